// ===== rtl/hmn_pkg.sv =====
package hmn_pkg;

  localparam int MAX_SIDE         = 512;
  localparam int MIN_SIDE         = 2;
  localparam int HEIGHT_FRAC_BITS = 8;
  localparam int NORMAL_FRAC_BITS = 14;

  localparam int GRID_W   = 10;
  localparam int IDX_W    = $clog2(MAX_SIDE);
  localparam int ROW_W    = IDX_W + 1;
  localparam int HEIGHT_W = 16;
  localparam int DIFF_W   = HEIGHT_W + 1;
  localparam int MAGD_W   = HEIGHT_W;
  localparam int SQ_W     = 2 * MAGD_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ENTRY_W  = 2 * HEIGHT_W;
  localparam int NORM_W   = 16;
  localparam int MAG_W    = NORMAL_FRAC_BITS + 1;

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(257);

  localparam int Y_VAL = 2 << HEIGHT_FRAC_BITS;
  localparam logic [SUM_W-1:0] Y_SQ = SUM_W'(Y_VAL * Y_VAL);

  localparam int QUO_W      = 2 * NORMAL_FRAC_BITS + 3;
  localparam int DIV_STEPS  = QUO_W - 1;
  localparam int ROOT_STEPS = (QUO_W + 1) / 2;
  localparam int ROOT_W     = 2 * ROOT_STEPS;
  localparam int UNIT_LAT   = DIV_STEPS + 1 + ROOT_STEPS + 1;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic             last;
    logic             neg_x;
    logic             neg_z;
  } side_t;

endpackage

// ===== rtl/hmn_ram.sv =====
module hmn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hmn_unit.sv =====
module hmn_unit import hmn_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [SUM_W-1:0] sq_i,
  output logic [MAG_W-1:0] mag_o
);

  logic [SUM_W-1:0]  rem_q [0:DIV_STEPS];
  logic [QUO_W-1:0]  quo_q [0:DIV_STEPS];
  logic [SUM_W-1:0]  sum_q [0:DIV_STEPS-1];
  logic [ROOT_W-1:0] rt_rem_q [0:ROOT_STEPS-1];
  logic [ROOT_W-1:0] rt_res_q [0:ROOT_STEPS-1];
  logic [MAG_W-1:0]  mag_q;

  logic             ge0;
  logic [SUM_W-1:0] diff0;

  assign ge0   = sq_i >= sum_i;
  assign diff0 = sq_i - sum_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ge0 ? diff0 : sq_i;
      quo_q[0] <= QUO_W'(ge0);
      sum_q[0] <= sum_i;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [SUM_W:0] r2;
    logic [SUM_W:0] diff;
    logic           ge;

    assign r2   = {rem_q[k-1], 1'b0};
    assign ge   = r2 >= {1'b0, sum_q[k-1]};
    assign diff = r2 - {1'b0, sum_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[SUM_W-1:0] : r2[SUM_W-1:0];
        quo_q[k] <= {quo_q[k-1][QUO_W-2:0], ge};
      end
    end

    if (k < DIV_STEPS) begin : g_sum
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sum_q[k] <= sum_q[k-1];
        end
      end
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - j));
    logic [ROOT_W-1:0] rem_in;
    logic [ROOT_W-1:0] res_in;
    logic [ROOT_W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = ROOT_W'(quo_q[DIV_STEPS]);
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rt_rem_q[j-1];
      assign res_in = rt_res_q[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rt_rem_q[j] <= rem_in - trial;
          rt_res_q[j] <= (res_in >> 1) + BIT;
        end else begin
          rt_rem_q[j] <= rem_in;
          rt_res_q[j] <= res_in >> 1;
        end
      end
    end
  end

  logic [ROOT_W-1:0] rounded;
  assign rounded = (rt_res_q[ROOT_STEPS-1] + ROOT_W'(1)) >> 1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= rounded[MAG_W-1:0];
    end
  end

  assign mag_o = mag_q;

endmodule

// ===== rtl/heightmap_normal_generator.sv =====
// Streams heights in raster order and returns the unit normal of each grid point one row
// late, plus one row of drain transactions to flush the last row. One transaction is taken
// per cycle; a normal reaches the output register from its accepted sample through stages
// 1 to 4 and the 31-step divider and 16-step square root pipelines of each component. Row
// history sits in two copies of a 512 x 32 RAM read at the column and the column after it.
// The whole pipeline, input included, holds while a result waits at the output and is not
// taken; grid_size must be written only while the block is idle.
module heightmap_normal_generator import hmn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       grid_size_we_i,
  input  logic [GRID_W-1:0]          grid_size_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic signed [HEIGHT_W-1:0] height_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [NORM_W-1:0]   normal_x_o,
  output logic [MAG_W-1:0]           normal_y_o,
  output logic signed [NORM_W-1:0]   normal_z_o,
  output logic [IDX_W-1:0]           col_o,
  output logic [IDX_W-1:0]           row_o,
  output logic                       last_o
);

  logic              advance;
  logic              accept;
  logic [GRID_W-1:0] grid_q;
  logic [GRID_W-1:0] n_eff;
  logic [IDX_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [ROW_W-1:0]  c_ext;
  logic [ROW_W-1:0]  c_inc;
  logic [ROW_W-1:0]  r_inc;
  logic [ROW_W-1:0]  r_dec;

  always_comb begin
    if (grid_q < GRID_W'(MIN_SIDE)) begin
      n_eff = GRID_W'(MIN_SIDE);
    end else if (grid_q > GRID_W'(MAX_SIDE)) begin
      n_eff = GRID_W'(MAX_SIDE);
    end else begin
      n_eff = grid_q;
    end
  end

  assign c_ext = {1'b0, col_q};
  assign c_inc = c_ext + ROW_W'(1);
  assign r_inc = row_q + ROW_W'(1);
  assign r_dec = row_q - ROW_W'(1);

  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (grid_size_we_i) begin
      grid_q <= grid_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (c_inc >= n_eff) begin
        col_q <= '0;
        row_q <= (r_inc > n_eff) ? '0 : r_inc;
      end else begin
        col_q <= c_inc[IDX_W-1:0];
      end
    end
  end

  // Stage 1: row buffer read returns, differences formed, entry written back.
  logic                       s1_valid_q;
  logic [IDX_W-1:0]           s1_col_q;
  logic [IDX_W-1:0]           s1_row_q;
  logic                       s1_last_q;
  logic                       s1_emit_q;
  logic                       s1_we_q;
  logic                       s1_ml_q;
  logic                       s1_mr_q;
  logic                       s1_mb_q;
  logic                       s1_rz_q;
  logic signed [HEIGHT_W-1:0] s1_sample_q;
  logic signed [HEIGHT_W-1:0] sample_d;

  logic                 fwd_a_q;
  logic                 fwd_b_q;
  logic [ENTRY_W-1:0]   fwd_data_q;
  logic [HEIGHT_W-1:0]  left_q;
  logic [ENTRY_W-1:0]   rd_a;
  logic [ENTRY_W-1:0]   rd_b;
  logic [ENTRY_W-1:0]   ent_a;
  logic [ENTRY_W-1:0]   ent_b;
  logic [ENTRY_W-1:0]   wdata;
  logic                 wr_en;

  assign sample_d = (cmd_e'(command_i) == CMD_DRAIN || row_q >= n_eff) ? '0 : height_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_a_q    <= 1'b0;
      fwd_b_q    <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
      fwd_a_q    <= wr_en && (s1_col_q == col_q);
      fwd_b_q    <= wr_en && (s1_col_q == c_inc[IDX_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fwd_data_q  <= wdata;
      s1_col_q    <= col_q;
      s1_row_q    <= r_dec[IDX_W-1:0];
      s1_last_q   <= (c_ext == n_eff - GRID_W'(1)) && (row_q == n_eff);
      s1_emit_q   <= (c_ext < n_eff) && (row_q >= ROW_W'(1)) && (row_q <= n_eff);
      s1_we_q     <= c_ext < n_eff;
      s1_ml_q     <= c_ext >= ROW_W'(1);
      s1_mr_q     <= c_inc < n_eff;
      s1_mb_q     <= row_q >= ROW_W'(2);
      s1_rz_q     <= row_q == '0;
      s1_sample_q <= sample_d;
      if (s1_valid_q) begin
        left_q <= ent_a[ENTRY_W-1:HEIGHT_W];
      end
    end
  end

  assign wr_en = s1_valid_q && s1_we_q;
  assign ent_a = fwd_a_q ? fwd_data_q : rd_a;
  assign ent_b = fwd_b_q ? fwd_data_q : rd_b;
  assign wdata = {s1_sample_q, s1_rz_q ? HEIGHT_W'(0) : ent_a[ENTRY_W-1:HEIGHT_W]};

  hmn_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SIDE)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_col_q),
    .wdata_i(wdata),
    .re_i   (advance),
    .raddr_i(col_q),
    .rdata_o(rd_a)
  );

  hmn_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SIDE)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_col_q),
    .wdata_i(wdata),
    .re_i   (advance),
    .raddr_i(c_inc[IDX_W-1:0]),
    .rdata_o(rd_b)
  );

  logic [HEIGHT_W-1:0]      left_v;
  logic [HEIGHT_W-1:0]      right_v;
  logic [HEIGHT_W-1:0]      below_v;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dz;
  logic [DIFF_W-1:0]        dx_abs;
  logic [DIFF_W-1:0]        dz_abs;

  assign left_v  = s1_ml_q ? left_q : '0;
  assign right_v = s1_mr_q ? ent_b[ENTRY_W-1:HEIGHT_W] : '0;
  assign below_v = s1_mb_q ? ent_a[HEIGHT_W-1:0] : '0;
  assign dx = $signed({left_v[HEIGHT_W-1], left_v}) - $signed({right_v[HEIGHT_W-1], right_v});
  assign dz = $signed({below_v[HEIGHT_W-1], below_v})
            - $signed({s1_sample_q[HEIGHT_W-1], s1_sample_q});
  assign dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign dz_abs = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

  // Stages 2 to 4: magnitudes, squares, sum of squares.
  logic              s2_valid_q;
  logic              s3_valid_q;
  logic              s4_valid_q;
  side_t             s2_side_q;
  side_t             s3_side_q;
  side_t             s4_side_q;
  logic [MAGD_W-1:0] s2_mx_q;
  logic [MAGD_W-1:0] s2_mz_q;
  logic [SQ_W-1:0]   s3_x2_q;
  logic [SQ_W-1:0]   s3_z2_q;
  logic [SUM_W-1:0]  s4_sum_q;
  logic [SUM_W-1:0]  s4_x2_q;
  logic [SUM_W-1:0]  s4_z2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_side_q <= '{col: s1_col_q, row: s1_row_q, last: s1_last_q,
                     neg_x: dx[DIFF_W-1], neg_z: dz[DIFF_W-1]};
      s2_mx_q   <= dx_abs[MAGD_W-1:0];
      s2_mz_q   <= dz_abs[MAGD_W-1:0];
      s3_side_q <= s2_side_q;
      s3_x2_q   <= {{MAGD_W{1'b0}}, s2_mx_q} * {{MAGD_W{1'b0}}, s2_mx_q};
      s3_z2_q   <= {{MAGD_W{1'b0}}, s2_mz_q} * {{MAGD_W{1'b0}}, s2_mz_q};
      s4_side_q <= s3_side_q;
      s4_sum_q  <= SUM_W'(s3_x2_q) + SUM_W'(s3_z2_q) + Y_SQ;
      s4_x2_q   <= SUM_W'(s3_x2_q);
      s4_z2_q   <= SUM_W'(s3_z2_q);
    end
  end

  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic [MAG_W-1:0] mag_z;

  hmn_unit u_unit_x (
    .clk_i(clk_i),
    .en_i (advance),
    .sum_i(s4_sum_q),
    .sq_i (s4_x2_q),
    .mag_o(mag_x)
  );

  hmn_unit u_unit_y (
    .clk_i(clk_i),
    .en_i (advance),
    .sum_i(s4_sum_q),
    .sq_i (Y_SQ),
    .mag_o(mag_y)
  );

  hmn_unit u_unit_z (
    .clk_i(clk_i),
    .en_i (advance),
    .sum_i(s4_sum_q),
    .sq_i (s4_z2_q),
    .mag_o(mag_z)
  );

  logic  pv_q   [UNIT_LAT];
  side_t side_q [UNIT_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < UNIT_LAT; i++) begin
        pv_q[i] <= 1'b0;
      end
    end else if (advance) begin
      pv_q[0] <= s4_valid_q;
      for (int i = 1; i < UNIT_LAT; i++) begin
        pv_q[i] <= pv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      side_q[0] <= s4_side_q;
      for (int i = 1; i < UNIT_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Output register.
  logic                     out_valid_q;
  logic                     end_valid;
  side_t                    end_side;
  logic signed [NORM_W-1:0] nx_q;
  logic [MAG_W-1:0]         ny_q;
  logic signed [NORM_W-1:0] nz_q;
  side_t                    out_side_q;
  logic [NORM_W-1:0]        mx_ext;
  logic [NORM_W-1:0]        mz_ext;

  assign end_valid = pv_q[UNIT_LAT-1];
  assign end_side  = side_q[UNIT_LAT-1];
  assign advance   = !out_valid_q || out_ready_i;
  assign mx_ext    = NORM_W'(mag_x);
  assign mz_ext    = NORM_W'(mag_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= end_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && end_valid) begin
      nx_q       <= end_side.neg_x ? -mx_ext : mx_ext;
      ny_q       <= mag_y;
      nz_q       <= end_side.neg_z ? -mz_ext : mz_ext;
      out_side_q <= end_side;
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign col_o       = out_side_q.col;
  assign row_o       = out_side_q.row;
  assign last_o      = out_side_q.last;

endmodule

// ===== tb/sv/tb_heightmap_normal_generator.sv =====
module tb_heightmap_normal_generator;
  import hmn_pkg::*;

  typedef struct {
    logic signed [NORM_W-1:0] nx;
    logic [MAG_W-1:0]         ny;
    logic signed [NORM_W-1:0] nz;
    logic [IDX_W-1:0]         col;
    logic [IDX_W-1:0]         row;
    logic                     last;
  } normal_t;

  class normal_scoreboard;
    logic signed [HEIGHT_W-1:0] upper_row[MAX_SIDE];
    logic signed [HEIGHT_W-1:0] lower_row[MAX_SIDE];
    int      col_cnt;
    int      row_cnt;
    int      side;
    int      fails;
    normal_t pending[$];

    function new();
      col_cnt = 0;
      row_cnt = 0;
      side    = int'(GRID_RESET);
      fails   = 0;
    endfunction

    function automatic int scale_component(longint v, longint sum_sq);
      logic [127:0] rhs;
      logic [127:0] lhs;
      longint       mag;
      longint       t;
      int           lo;
      int           hi;
      int           mid;
      mag = (v < 0) ? -v : v;
      rhs = 128'(mag * mag) << (2 * NORMAL_FRAC_BITS + 2);
      lo  = 0;
      hi  = 1 << NORMAL_FRAC_BITS;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        t   = 2 * mid - 1;
        lhs = 128'(t * t) * 128'(sum_sq);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return (v < 0) ? -lo : lo;
    endfunction

    function void note_sample(cmd_e cmd, logic signed [HEIGHT_W-1:0] h);
      int      n;
      longint  s;
      longint  left;
      longint  right;
      longint  below;
      longint  dx;
      longint  dz;
      longint  sum_sq;
      normal_t e;
      n = side;
      if (n < MIN_SIDE) n = MIN_SIDE;
      if (n > MAX_SIDE) n = MAX_SIDE;
      s = h;
      if (cmd == CMD_DRAIN || row_cnt >= n) s = 0;
      if (col_cnt < n && row_cnt >= 1 && row_cnt <= n) begin
        left   = (col_cnt >= 1) ? longint'(upper_row[col_cnt-1]) : 0;
        right  = (col_cnt + 1 < n) ? longint'(lower_row[col_cnt+1]) : 0;
        below  = (row_cnt >= 2) ? longint'(upper_row[col_cnt]) : 0;
        dx     = left - right;
        dz     = below - s;
        sum_sq = dx * dx + dz * dz + longint'(Y_VAL) * Y_VAL;
        e.nx   = NORM_W'(scale_component(dx, sum_sq));
        e.ny   = MAG_W'(scale_component(Y_VAL, sum_sq));
        e.nz   = NORM_W'(scale_component(dz, sum_sq));
        e.col  = IDX_W'(col_cnt);
        e.row  = IDX_W'(row_cnt - 1);
        e.last = (col_cnt == n - 1 && row_cnt == n);
        pending.push_back(e);
      end
      if (col_cnt < n) begin
        upper_row[col_cnt] = (row_cnt == 0) ? '0 : lower_row[col_cnt];
        lower_row[col_cnt] = HEIGHT_W'(s);
      end
      if (col_cnt + 1 >= n) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1 > n) ? 0 : row_cnt + 1;
      end else begin
        col_cnt++;
      end
    endfunction

    function void check_normal(normal_t got);
      normal_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected normal col %0d row %0d", $time, got.col, got.row);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (got.nx !== e.nx) begin
        $display("%0t: normal_x exp %0d got %0d", $time, e.nx, got.nx);
        fails++;
      end
      if (got.ny !== e.ny) begin
        $display("%0t: normal_y exp %0d got %0d", $time, e.ny, got.ny);
        fails++;
      end
      if (got.nz !== e.nz) begin
        $display("%0t: normal_z exp %0d got %0d", $time, e.nz, got.nz);
        fails++;
      end
      if (got.col !== e.col) begin
        $display("%0t: col exp %0d got %0d", $time, e.col, got.col);
        fails++;
      end
      if (got.row !== e.row) begin
        $display("%0t: row exp %0d got %0d", $time, e.row, got.row);
        fails++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last exp %0d got %0d", $time, e.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       grid_size_we;
  logic [GRID_W-1:0]          grid_size;
  logic                       in_valid;
  logic                       in_ready;
  cmd_e                       command;
  logic signed [HEIGHT_W-1:0] height;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [NORM_W-1:0]   normal_x;
  logic [MAG_W-1:0]           normal_y;
  logic signed [NORM_W-1:0]   normal_z;
  logic [IDX_W-1:0]           col;
  logic [IDX_W-1:0]           row;
  logic                       last;

  normal_scoreboard sb = new();
  bit  no_idle;
  bit  hold_req;
  int  idle_cycles;
  int  items_sent;

  heightmap_normal_generator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grid_size_we_i (grid_size_we),
    .grid_size_i    (grid_size),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .height_i       (height),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .normal_x_o     (normal_x),
    .normal_y_o     (normal_y),
    .normal_z_o     (normal_z),
    .col_o          (col),
    .row_o          (row),
    .last_o         (last)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return HEIGHT_W'($urandom_range(0, 1023)) - 16'sd512;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic send(cmd_e cmd, logic signed [HEIGHT_W-1:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command  = cmd;
    height   = h;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sb.note_sample(cmd, h);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending.size() > 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_grid(logic [GRID_W-1:0] value);
    drain_results();
    grid_size_we = 1'b1;
    grid_size    = value;
    sb.side      = int'(value);
    @(negedge clk_i);
    grid_size_we = 1'b0;
  endtask

  task automatic run_grid(int n);
    for (int r = 0; r <= n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (r == n)
          send(($urandom_range(0, 9) < 8) ? CMD_DRAIN : CMD_SAMPLE, pick_height());
        else
          send(($urandom_range(0, 9) == 0) ? CMD_DRAIN : CMD_SAMPLE, pick_height());
      end
    end
  endtask

  initial begin
    int busy;
    busy      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready = 1'b1;
      end else if (busy > 0) begin
        out_ready = 1'b0;
        busy--;
      end else begin
        case ($urandom_range(0, 19))
          0: busy = $urandom_range(10, 40);
          1, 2, 3, 4: busy = $urandom_range(0, 3);
          default: busy = 0;
        endcase
        out_ready = (busy == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    normal_t got;
    if (rst_ni && out_valid && out_ready) begin
      got.nx   = normal_x;
      got.ny   = normal_y;
      got.nz   = normal_z;
      got.col  = col;
      got.row  = row;
      got.last = last;
      sb.check_normal(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sizes[$];
    rst_ni       = 1'b0;
    grid_size_we = 1'b0;
    grid_size    = '0;
    in_valid     = 1'b0;
    command      = CMD_SAMPLE;
    height       = '0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    items_sent   = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    write_grid(GRID_W'(2));
    send(CMD_SAMPLE, 16'sh7fff);
    send(CMD_SAMPLE, 16'sh8000);
    send(CMD_DRAIN, 16'sh7fff);
    send(CMD_SAMPLE, 16'sh8000);
    send(CMD_DRAIN, 16'sh0000);
    send(CMD_SAMPLE, 16'sh7fff);
    send(CMD_SAMPLE, 16'sh8000);
    send(CMD_SAMPLE, 16'sh8000);
    send(CMD_SAMPLE, 16'sh7fff);
    send(CMD_SAMPLE, 16'sh7fff);
    send(CMD_SAMPLE, 16'sh0001);
    send(CMD_SAMPLE, 16'shffff);

    sizes = '{0, 1, 3, 16, 5, 7, 4, 9};
    foreach (sizes[i]) begin
      write_grid(GRID_W'(sizes[i]));
      no_idle  = (sizes[i] == 7);
      hold_req = (sizes[i] == 16);
      run_grid((sizes[i] < MIN_SIDE) ? MIN_SIDE :
               (sizes[i] > MAX_SIDE) ? MAX_SIDE : sizes[i]);
    end
    no_idle = 1'b0;

    while (items_sent < 1050) begin
      write_grid(GRID_W'($urandom_range(2, 12)));
      run_grid(sb.side);
    end

    drain_results();
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
